@@ rtl/core/lpns_pkg.sv @@
// ----------------------------------------------------------------------------
// lpns_pkg: shared types and constants of the light pool
// Opcodes, status codes, register map and the slot record layout.
// ----------------------------------------------------------------------------
package lpns_pkg;

  localparam int LIGHT_SLOTS_DEF = 16;
  localparam int MAX_RESULTS = 16;

  localparam logic [1:0] OP_SPAWN  = 2'd0;
  localparam logic [1:0] OP_TICK   = 2'd1;
  localparam logic [1:0] OP_SUBMIT = 2'd2;
  localparam logic [1:0] OP_CLEAR  = 2'd3;

  localparam logic [2:0] ST_SPAWNED = 3'd0;
  localparam logic [2:0] ST_FULL    = 3'd1;
  localparam logic [2:0] ST_DONE    = 3'd2;
  localparam logic [2:0] ST_EMIT    = 3'd3;
  localparam logic [2:0] ST_NONE    = 3'd4;

  localparam logic [1:0] REG_MAX_SUBMIT    = 2'd0;
  localparam logic [1:0] REG_CULL_MARGIN   = 2'd1;
  localparam logic [1:0] REG_MIN_INTENSITY = 2'd2;

  localparam logic [23:0] AGE_MAX = 24'hFFFFFF;
  localparam logic [16:0] FADE_ONE = 17'h10000;

  // one slot record as stored in the slot memory
  typedef struct packed {
    logic [31:0] id;
    logic [23:0] x;
    logic [23:0] y;
    logic [23:0] z;
    logic [23:0] color;
    logic [15:0] intensity;
    logic [23:0] radius;
    logic [23:0] lifetime;
    logic [23:0] age;
    logic [23:0] fade_in;
    logic [23:0] fade_out;
  } slot_rec_t;

  localparam int REC_W = $bits(slot_rec_t);

endpackage

@@ rtl/core/lpns_ram.sv @@
// ----------------------------------------------------------------------------
// lpns_ram: generic single-port RAM
// One write or one read per cycle, read data registered.
// ----------------------------------------------------------------------------
module lpns_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

@@ rtl/core/light_pool_nearest_select_core.sv @@
// ----------------------------------------------------------------------------
// light_pool_nearest_select_core: pool of point lights with nearest select
// Spawn, tick, clear and submit (cull, fade, sort by distance, emit).
// ----------------------------------------------------------------------------
// Steps: spawn goes through S_SPAWN to S_RESP, clear straight to S_RESP; tick
// reads each slot (S_TRD) and writes its age back for an active slot (S_TWR).
// Submit: per slot a read (S_SRD), the distance (difference, magnitude, square,
// sum), a 41-step fade divide where a fade applies, then a drop or up to NQ+2
// insertion steps; then a read (S_ERD) and an output (S_EOUT) per emitted item.
// One item at a time; the next item is taken once the last result has left.
// Reset (synchronous, rst high) clears active bits, id counter, submit count
// and registers to their defaults; the slot memory holds no reset.
module light_pool_nearest_select_core #(
  parameter int LIGHT_SLOTS = lpns_pkg::LIGHT_SLOTS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  // APB configuration
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready,
  // input item stream
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [1:0]   s_tuser,  // op
  // pos_x, pos_y, pos_z, color_rgb, intensity, radius, lifetime, fade_in,
  // fade_out, delta_time (low bits first)
  input  logic [231:0] s_tdata,
  // result item stream
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [2:0]   m_tuser,  // status
  output logic         m_tlast,
  // out_id, out_x, out_y, out_z, out_color, out_radius, out_intensity,
  // submit_count, active_count, 6 zero pad bits
  output logic [183:0] m_tdata
);
  localparam int SW = (LIGHT_SLOTS > 1) ? $clog2(LIGHT_SLOTS) : 1;
  localparam int CW = $clog2(LIGHT_SLOTS + 1);
  localparam int NQ = (LIGHT_SLOTS < lpns_pkg::MAX_RESULTS) ? LIGHT_SLOTS
                                                           : lpns_pkg::MAX_RESULTS;
  localparam int QW = $clog2(NQ + 1);
  localparam int QIW = (NQ > 1) ? $clog2(NQ) : 1;

  typedef enum logic [10:0] {
    S_IDLE   = 11'b00000000001,
    S_SPAWN  = 11'b00000000010,
    S_TRD    = 11'b00000000100,
    S_TWR    = 11'b00000001000,
    S_SRD    = 11'b00000010000,
    S_SDIST  = 11'b00000100000,
    S_SDIV   = 11'b00001000000,
    S_SINS   = 11'b00010000000,
    S_ERD    = 11'b00100000000,
    S_EOUT   = 11'b01000000000,
    S_RESP   = 11'b10000000000
  } state_t;

  state_t state;

  // ------------------------------------------------------------ registers
  logic [4:0]  max_submit;
  logic [23:0] cull_margin;
  logic [15:0] min_intensity;

  logic        wr_cfg;
  assign pready = 1'b1;
  assign wr_cfg = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_submit    <= 5'd16;
      cull_margin   <= 24'd5120;
      min_intensity <= 16'd3;
    end else if (wr_cfg) begin
      case (paddr[3:2])
        lpns_pkg::REG_MAX_SUBMIT:    max_submit    <= pwdata[4:0];
        lpns_pkg::REG_CULL_MARGIN:   cull_margin   <= pwdata[23:0];
        lpns_pkg::REG_MIN_INTENSITY: min_intensity <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      lpns_pkg::REG_MAX_SUBMIT:    prdata = {27'd0, max_submit};
      lpns_pkg::REG_CULL_MARGIN:   prdata = {8'd0, cull_margin};
      lpns_pkg::REG_MIN_INTENSITY: prdata = {16'd0, min_intensity};
      default:                     prdata = 32'd0;
    endcase
  end

  // ------------------------------------------------------------ input hold
  logic [1:0]   op;
  logic [231:0] din;
  wire  [23:0]  in_x  = din[23:0];
  wire  [23:0]  in_y  = din[47:24];
  wire  [23:0]  in_z  = din[71:48];
  wire  [23:0]  in_dt = din[231:208];

  // ------------------------------------------------------------ slot memory
  logic                     ram_we;
  logic [SW-1:0]            ram_addr;
  lpns_pkg::slot_rec_t      ram_wdata, ram_rdata;

  lpns_ram #(.WIDTH(lpns_pkg::REC_W), .DEPTH(1 << SW)) u_slots (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
  );

  logic [LIGHT_SLOTS-1:0] active;
  logic [31:0]            next_id;
  logic [4:0]             last_submitted;
  logic [SW-1:0]          slot;       // scan index
  logic                   free_found;
  logic [SW-1:0]          free_slot;
  logic [CW-1:0]          act_cnt;

  always_comb begin
    free_found = 1'b0;
    free_slot  = '0;
    act_cnt    = '0;
    for (int i = LIGHT_SLOTS - 1; i >= 0; i--) begin
      if (!active[i]) begin
        free_found = 1'b1;
        free_slot  = SW'(i);
      end
      act_cnt = act_cnt + CW'(active[i]);
    end
  end

  // ------------------------------------------------------------ distance
  logic signed [24:0] ddx, ddy, ddz;
  logic [23:0]        adx, ady, adz;
  logic [47:0]        sqx, sqy, sqz;
  logic [49:0]        lim_sq;
  logic [49:0]        d2;
  logic [24:0]        lim;
  logic [1:0]         dstep;

  // ------------------------------------------------------------ fade divider
  logic [40:0] num;     // dividend, shifted up
  logic [24:0] rem;
  logic [40:0] quo;
  logic [23:0] dvs;
  logic [5:0]  dcnt;
  logic [16:0] fade;
  logic [32:0] fprod;
  logic        need_div;
  logic [25:0] rem_sh;

  // ------------------------------------------------------------ candidate list
  logic [49:0]   qd   [NQ];
  logic [SW-1:0] qs   [NQ];
  logic [15:0]   qi   [NQ];
  logic [QW-1:0] nc;
  logic [QW-1:0] ins;   // insertion walk position
  logic [49:0]   cd;
  logic [15:0]   cfi;
  logic [QW-1:0] ek;
  logic [QW-1:0] cap, emit_n;
  logic          keep;

  assign cap = (max_submit > 5'(NQ)) ? QW'(NQ) : QW'(max_submit);
  assign emit_n = (nc < cap) ? nc : cap;

  // ------------------------------------------------------------ output
  logic [2:0]   o_status;
  logic         o_last;
  logic [31:0]  o_id;
  logic [23:0]  o_x, o_y, o_z, o_color, o_radius;
  logic [15:0]  o_int;

  assign s_tready = (state == S_IDLE) && !m_tvalid;
  assign m_tuser  = o_status;
  assign m_tlast  = o_last;
  assign m_tdata  = {6'd0, 5'(act_cnt), last_submitted, o_int, o_radius, o_color,
                     o_z, o_y, o_x, o_id};

  lpns_pkg::slot_rec_t rec;
  logic [24:0] aged;
  assign aged = {1'b0, ram_rdata.age} + {1'b0, in_dt};

  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = slot;
    ram_wdata = ram_rdata;
    rec       = ram_rdata;
    if (state == S_SPAWN) begin
      // write only when a slot is free, never over an active light
      ram_we = free_found;
      ram_addr = free_slot;
      rec.id = next_id;
      rec.x = din[23:0];          rec.y = din[47:24];        rec.z = din[71:48];
      rec.color = din[95:72];     rec.intensity = din[111:96];
      rec.radius = din[135:112];  rec.lifetime = din[159:136];
      rec.age = '0;               rec.fade_in = din[183:160];
      rec.fade_out = din[207:184];
      ram_wdata = rec;
    end else if (state == S_TWR) begin
      ram_we = active[slot];
      rec.age = aged[24] ? lpns_pkg::AGE_MAX : aged[23:0];
      ram_wdata = rec;
    end else if (state == S_ERD) begin
      ram_addr = qs[QIW'(ek)];
    end
  end

  assign rem_sh = {rem, num[40]};
  assign fprod  = ram_rdata.intensity * fade;

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      active         <= '0;
      next_id        <= '0;
      last_submitted <= '0;
      m_tvalid       <= 1'b0;
      slot           <= '0;
      nc             <= '0;
    end else begin
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (s_tvalid && s_tready) begin
            op  <= s_tuser;
            din <= s_tdata;
            slot <= '0;
            nc   <= '0;
            case (s_tuser)
              lpns_pkg::OP_SPAWN:  state <= S_SPAWN;
              lpns_pkg::OP_TICK:   state <= S_TRD;
              lpns_pkg::OP_SUBMIT: state <= S_SRD;
              default: begin
                active <= '0;
                last_submitted <= '0;
                state <= S_RESP;
              end
            endcase
          end
        end
        S_SPAWN: begin
          // latch the outcome before the active bits change
          if (free_found) begin
            o_status <= lpns_pkg::ST_SPAWNED;
            o_id <= next_id;
            active[free_slot] <= 1'b1;
            next_id <= next_id + 32'd1;
          end else begin
            o_status <= lpns_pkg::ST_FULL;
            o_id <= '0;
          end
          state <= S_RESP;
        end
        S_TRD: state <= S_TWR;
        S_TWR: begin
          if (active[slot] &&
              (aged[24] ? lpns_pkg::AGE_MAX : aged[23:0]) >= ram_rdata.lifetime)
            active[slot] <= 1'b0;
          if (slot == SW'(LIGHT_SLOTS - 1)) state <= S_RESP;
          else begin
            slot <= slot + SW'(1);
            state <= S_TRD;
          end
        end
        S_SRD: begin
          dstep <= '0;
          state <= S_SDIST;
        end
        S_SDIST: begin
          dstep <= dstep + 2'd1;
          if (dstep == 2'd0) begin
            ddx <= $signed({ram_rdata.x[23], ram_rdata.x}) - $signed({in_x[23], in_x});
            ddy <= $signed({ram_rdata.y[23], ram_rdata.y}) - $signed({in_y[23], in_y});
            ddz <= $signed({ram_rdata.z[23], ram_rdata.z}) - $signed({in_z[23], in_z});
            lim <= {1'b0, ram_rdata.radius} + {1'b0, cull_margin};
          end else if (dstep == 2'd1) begin
            // |d| fits 24 bits unsigned since coordinates are 24-bit signed
            adx <= ddx[24] ? 24'(-ddx) : ddx[23:0];
            ady <= ddy[24] ? 24'(-ddy) : ddy[23:0];
            adz <= ddz[24] ? 24'(-ddz) : ddz[23:0];
          end else if (dstep == 2'd2) begin
            sqx <= adx * adx;
            sqy <= ady * ady;
            sqz <= adz * adz;
            lim_sq <= 50'(lim) * 50'(lim);
          end else begin
            d2 <= {2'd0, sqx} + {2'd0, sqy} + {2'd0, sqz};
            // set up the fade division; fade-out overrides fade-in
            if (ram_rdata.fade_out != 0 &&
                {1'b0, ram_rdata.age} + {1'b0, ram_rdata.fade_out} >
                {1'b0, ram_rdata.lifetime}) begin
              if (ram_rdata.age >= ram_rdata.lifetime) begin
                fade <= '0;
                need_div <= 1'b0;
              end else begin
                fade <= lpns_pkg::FADE_ONE;
                need_div <= 1'b1;
                num <= {ram_rdata.lifetime - ram_rdata.age, 17'd0};
                dvs <= ram_rdata.fade_out;
              end
            end else if (ram_rdata.fade_in != 0 && ram_rdata.age < ram_rdata.fade_in) begin
              fade <= lpns_pkg::FADE_ONE;
              need_div <= 1'b1;
              num <= {ram_rdata.age, 17'd0};
              dvs <= ram_rdata.fade_in;
            end else begin
              fade <= lpns_pkg::FADE_ONE;
              need_div <= 1'b0;
            end
            rem  <= '0;
            quo  <= '0;
            dcnt <= '0;
            state <= S_SDIV;
          end
        end
        S_SDIV: begin
          // restoring division, one quotient bit a cycle, 41 steps
          if (need_div) begin
            num  <= num << 1;
            if (rem_sh >= {2'd0, dvs}) begin
              rem <= 25'(rem_sh - {2'd0, dvs});
              quo <= {quo[39:0], 1'b1};
            end else begin
              rem <= rem_sh[24:0];
              quo <= {quo[39:0], 1'b0};
            end
            dcnt <= dcnt + 6'd1;
            if (dcnt == 6'd40) need_div <= 1'b0;
          end else begin
            if (dcnt != 0) begin
              // quotient has one extra low bit (dividend shifted by 17)
              fade <= (quo[40:1] > 40'(lpns_pkg::FADE_ONE)) ? lpns_pkg::FADE_ONE
                                                              : quo[17:1];
              dcnt <= '0;
            end else begin
              cd  <= d2;
              cfi <= fprod[31:16];
              keep <= active[slot] &&
                      (d2 <= lim_sq) &&
                      (fprod[31:16] >= min_intensity);
              ins <= nc;
              state <= S_SINS;
            end
          end
        end
        S_SINS: begin
          if (!keep) begin
            state <= (slot == SW'(LIGHT_SLOTS - 1)) ? S_ERD : S_SRD;
            slot <= slot + SW'(1);
            ek <= '0;
          end else if (ins != 0 && qd[QIW'(ins - QW'(1))] > cd) begin
            if (ins < QW'(NQ)) begin
              qd[QIW'(ins)] <= qd[QIW'(ins - QW'(1))];
              qs[QIW'(ins)] <= qs[QIW'(ins - QW'(1))];
              qi[QIW'(ins)] <= qi[QIW'(ins - QW'(1))];
            end
            ins <= ins - QW'(1);
          end else begin
            if (ins < QW'(NQ)) begin
              qd[QIW'(ins)] <= cd;
              qs[QIW'(ins)] <= slot;
              qi[QIW'(ins)] <= cfi;
            end
            if (nc < QW'(NQ)) nc <= nc + QW'(1);
            keep <= 1'b0;
          end
        end
        S_ERD: begin
          if (ek == '0) last_submitted <= 5'(emit_n);
          if (emit_n == 0) state <= S_RESP;
          else if (!m_tvalid || m_tready) state <= S_EOUT;
        end
        S_EOUT: begin
          o_status <= lpns_pkg::ST_EMIT;
          o_last   <= (ek == emit_n - QW'(1));
          o_id <= ram_rdata.id;  o_x <= ram_rdata.x;  o_y <= ram_rdata.y;
          o_z <= ram_rdata.z;    o_color <= ram_rdata.color;
          o_radius <= ram_rdata.radius;
          o_int <= qi[QIW'(ek)];
          m_tvalid <= 1'b1;
          ek <= ek + QW'(1);
          state <= (ek == emit_n - QW'(1)) ? S_IDLE : S_ERD;
        end
        S_RESP: begin
          o_last <= 1'b1;
          o_x <= '0; o_y <= '0; o_z <= '0; o_color <= '0; o_radius <= '0; o_int <= '0;
          // spawn status and id were set in the spawn cycle
          if (op != lpns_pkg::OP_SPAWN) begin
            o_id <= '0;
            o_status <= (op == lpns_pkg::OP_SUBMIT) ? lpns_pkg::ST_NONE
                                                    : lpns_pkg::ST_DONE;
          end
          m_tvalid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // ------------------------------------------------------------ checks
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !s_tready) else $error("input taken while busy");
  a_nc_bound: assert property (@(posedge clk) disable iff (rst)
    nc <= QW'(NQ)) else $error("candidate count overflow");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> $stable(m_tdata)) else $error("result changed");
endmodule
